// ===== src/uuidg_pkg.sv =====
// Shared types, register codes and helper functions of the UUID generator.
package uuidg_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned TS_W        = 48;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned CNT_LOW_W   = 62;
	localparam int unsigned CNT_HIGH_W  = 12;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VERSION_MODE  = 3'd0,
		REG_OVERFLOW_WAIT = 3'd1,
		REG_ENTROPY_MIXER = 3'd2,
		REG_REGRESSION_MS = 3'd3,
		REG_SAVE_ENABLE   = 3'd4,
		REG_SAVE_INTERVAL = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REJECTED  = 2'd1,
		ST_OVF_FAIL  = 2'd2,
		ST_OVF_RETRY = 2'd3
	} status_t;

	localparam logic [2:0]  MODE_RANDOM      = 3'd4;
	localparam logic [2:0]  MODE_RESET       = 3'd7;
	localparam logic [31:0] REGRESSION_RESET = 32'd10000;
	localparam logic [3:0]  VER_NIB_RANDOM   = 4'h4;
	localparam logic [3:0]  VER_NIB_TIME     = 4'h7;
	localparam logic [1:0]  VARIANT_BITS     = 2'b10;

	typedef struct packed {
		logic [2:0]        version_mode;
		logic              overflow_wait;
		logic [WORD_W-1:0] entropy_mixer;
		logic [31:0]       regression_threshold_ms;
		logic              save_enable;
		logic [31:0]       save_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] random_high;
		logic [WORD_W-1:0] random_low;
		logic [TS_W-1:0]   now_ms;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] uuid_high;
		logic [WORD_W-1:0] uuid_low;
		logic              save_request;
		logic [TS_W-1:0]   save_timestamp;
	} rsp_t;

	typedef struct packed {
		logic [TS_W-1:0]   last_timestamp;
		logic [WORD_W-1:0] store_high;
		logic [WORD_W-1:0] store_low;
		logic [TS_W-1:0]   last_saved_time;
		logic              overflow_flag;
	} state_t;

	function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = v[8*(7-i) +: 8];
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] set_version(input logic [WORD_W-1:0] hi,
			input logic [3:0] nib);
		return {hi[63:16], nib, hi[11:0]};
	endfunction

	function automatic logic [WORD_W-1:0] set_variant(input logic [WORD_W-1:0] lo);
		return {VARIANT_BITS, lo[61:0]};
	endfunction

endpackage

// ===== src/uuidg_if.sv =====
// Valid/ready channel interfaces for generate requests and results.
interface uuidg_req_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_high;
	logic [63:0] random_low;
	logic [47:0] now_ms;

	modport source (output valid, random_high, random_low, now_ms, input ready);
	modport sink (input valid, random_high, random_low, now_ms, output ready);
endinterface

interface uuidg_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] uuid_high;
	logic [63:0] uuid_low;
	logic        save_request;
	logic [47:0] save_timestamp;

	modport source (output valid, status, uuid_high, uuid_low, save_request, save_timestamp,
		input ready);
	modport sink (input valid, status, uuid_high, uuid_low, save_request, save_timestamp,
		output ready);
endinterface

// ===== src/uuidg_cfg_regs.sv =====
// Configuration register file with a plain indexed write port.
module uuidg_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [uuidg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [uuidg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output uuidg_pkg::cfg_t                   cfg
);

	uuidg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_mode            <= uuidg_pkg::MODE_RESET;
			cfg_q.overflow_wait           <= 1'b0;
			cfg_q.entropy_mixer           <= '0;
			cfg_q.regression_threshold_ms <= uuidg_pkg::REGRESSION_RESET;
			cfg_q.save_enable             <= 1'b0;
			cfg_q.save_interval_ms        <= '0;
		end else if (cfg_we) begin
			unique case (uuidg_pkg::reg_index_t'(cfg_index))
				uuidg_pkg::REG_VERSION_MODE:  cfg_q.version_mode <= cfg_data[2:0];
				uuidg_pkg::REG_OVERFLOW_WAIT: cfg_q.overflow_wait <= cfg_data[0];
				uuidg_pkg::REG_ENTROPY_MIXER: cfg_q.entropy_mixer <= cfg_data;
				uuidg_pkg::REG_REGRESSION_MS: cfg_q.regression_threshold_ms <= cfg_data[31:0];
				uuidg_pkg::REG_SAVE_ENABLE:   cfg_q.save_enable <= cfg_data[0];
				uuidg_pkg::REG_SAVE_INTERVAL: cfg_q.save_interval_ms <= cfg_data[31:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/uuidg_step.sv =====
// Combinational generate step: result and next generator state for one request.
module uuidg_step (
	input  uuidg_pkg::cfg_t   cfg,
	input  uuidg_pkg::req_t   req,
	input  uuidg_pkg::state_t st,
	output uuidg_pkg::rsp_t   rsp,
	output uuidg_pkg::state_t st_next
);

	logic [63:0]                   rl_mix;
	logic                          rand_zero;
	logic                          major_regress;
	logic [48:0]                   now_plus_thr;
	logic [74:0]                   cnt_sum;
	logic                          success;
	logic [47:0]                   now_eff;
	logic [48:0]                   save_limit;
	uuidg_pkg::status_t            ovf_status;

	assign rl_mix        = req.random_low ^ uuidg_pkg::swap_bytes(cfg.entropy_mixer);
	assign rand_zero     = (req.random_high | req.random_low) == '0;
	assign now_plus_thr  = {1'b0, req.now_ms} + {17'd0, cfg.regression_threshold_ms};
	assign major_regress = (req.now_ms < st.last_timestamp)
		&& (now_plus_thr < {1'b0, st.last_timestamp});
	// 74-bit counter skips the version nibble and the variant bits
	assign cnt_sum       = {1'b0, st.store_high[11:0], st.store_low[61:0]} + 75'd1;
	assign ovf_status    = cfg.overflow_wait ? uuidg_pkg::ST_OVF_RETRY : uuidg_pkg::ST_OVF_FAIL;

	always_comb begin
		rsp        = '0;
		rsp.status = uuidg_pkg::ST_OK;
		st_next    = st;
		success    = 1'b0;
		now_eff    = req.now_ms;
		save_limit = '0;
		if (cfg.version_mode == uuidg_pkg::MODE_RANDOM) begin
			if (rand_zero) begin
				rsp.status         = uuidg_pkg::ST_REJECTED;
				st_next.store_high = '0;
				st_next.store_low  = '0;
			end else begin
				st_next.store_high = uuidg_pkg::set_version(req.random_high,
					uuidg_pkg::VER_NIB_RANDOM);
				st_next.store_low  = uuidg_pkg::set_variant(req.random_low);
				rsp.uuid_high      = st_next.store_high;
				rsp.uuid_low       = st_next.store_low;
			end
		end else if (rand_zero || req.now_ms == '0) begin
			rsp.status = uuidg_pkg::ST_REJECTED;
		end else if (major_regress) begin
			// fall back to a random UUID, keep timestamp and overflow state
			st_next.store_high = uuidg_pkg::set_version(req.random_high,
				uuidg_pkg::VER_NIB_RANDOM);
			st_next.store_low  = uuidg_pkg::set_variant(rl_mix);
			rsp.uuid_high      = st_next.store_high;
			rsp.uuid_low       = st_next.store_low;
		end else begin
			if (req.now_ms > st.last_timestamp) begin
				st_next.last_timestamp = req.now_ms;
				st_next.store_high     = req.random_high;
				st_next.store_low      = rl_mix;
				st_next.overflow_flag  = 1'b0;
				success                = 1'b1;
			end else begin
				// same millisecond or minor regression: clamp to the last time
				now_eff = st.last_timestamp;
				if (st.overflow_flag) begin
					rsp.status = ovf_status;
				end else if (st.store_high[15:12] != uuidg_pkg::VER_NIB_TIME) begin
					st_next.store_high = req.random_high;
					st_next.store_low  = rl_mix;
					success            = 1'b1;
				end else begin
					st_next.store_high = {st.store_high[63:12], cnt_sum[73:62]};
					st_next.store_low  = {st.store_low[63:62], cnt_sum[61:0]};
					if (cnt_sum[74]) begin
						st_next.overflow_flag = 1'b1;
						rsp.status            = ovf_status;
					end else begin
						success = 1'b1;
					end
				end
			end
			if (success) begin
				st_next.store_high = uuidg_pkg::set_version(
					{st_next.last_timestamp, st_next.store_high[15:0]},
					uuidg_pkg::VER_NIB_TIME);
				st_next.store_low  = uuidg_pkg::set_variant(st_next.store_low);
				rsp.uuid_high      = st_next.store_high;
				rsp.uuid_low       = st_next.store_low;
				save_limit = {1'b0, st.last_saved_time} + {17'd0, cfg.save_interval_ms};
				if (cfg.save_enable && ({1'b0, now_eff} > save_limit)) begin
					st_next.last_saved_time = now_eff;
					rsp.save_request        = 1'b1;
					rsp.save_timestamp      = now_eff;
				end
			end
		end
	end

endmodule

// ===== src/monotonic_uuid_v7_generator_core.sv =====
// Top level of the monotonic time-ordered UUID generator.
//
//  channel  direction  handshake      contents
//  req      in         valid/ready    random_high, random_low, now_ms
//  rsp      out        valid/ready    status, uuid_high, uuid_low, save_request, save_timestamp
//  cfg      in         cfg_we only    cfg_index, cfg_data
//
// One request per cycle sustained while rsp is ready: an input register feeds one combinational
// step whose result and generator state are registered together.
// An accepted request is held in the input register; its result is shown on rsp once the
// step has run and its result is registered in the output stage.
// A stalled rsp holds its result; req keeps taking one more request until the
// input register is also full, then ready drops.
// Reset empties both stages, zeroes generator state and loads configuration defaults.
module monotonic_uuid_v7_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [uuidg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [uuidg_pkg::CFG_DATA_W-1:0]  cfg_data,
	uuidg_req_if.sink                         req,
	uuidg_rsp_if.source                       rsp
);

	uuidg_pkg::cfg_t   cfg;
	uuidg_pkg::req_t   req_s1;
	logic              valid_s1;
	uuidg_pkg::rsp_t   rsp_next;
	uuidg_pkg::rsp_t   rsp_s2;
	logic              valid_s2;
	uuidg_pkg::state_t state_q;
	uuidg_pkg::state_t state_next;
	logic              advance;

	uuidg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uuidg_step u_step (
		.cfg     (cfg),
		.req     (req_s1),
		.st      (state_q),
		.rsp     (rsp_next),
		.st_next (state_next)
	);

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.random_high <= req.random_high;
			req_s1.random_low  <= req.random_low;
			req_s1.now_ms      <= req.now_ms;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.status         = rsp_s2.status;
	assign rsp.uuid_high      = rsp_s2.uuid_high;
	assign rsp.uuid_low       = rsp_s2.uuid_low;
	assign rsp.save_request   = rsp_s2.save_request;
	assign rsp.save_timestamp = rsp_s2.save_timestamp;

endmodule

// ===== src/uuidg_checker.sv =====
// Port-level checks of the UUID generator, bound to the top level.
module uuidg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [63:0] rsp_uuid_high,
	input logic [63:0] rsp_uuid_low,
	input logic        rsp_save_request,
	input logic [47:0] rsp_save_timestamp
);

	// a stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_uuid_high)
			&& $stable(rsp_uuid_low) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != uuidg_pkg::ST_OK |->
			rsp_uuid_high == '0 && rsp_uuid_low == '0 && !rsp_save_request)
		else $error("failed transaction carries a UUID or save request");

	a_ok_format: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == uuidg_pkg::ST_OK |->
			(rsp_uuid_high[15:12] == uuidg_pkg::VER_NIB_TIME
				|| rsp_uuid_high[15:12] == uuidg_pkg::VER_NIB_RANDOM)
			&& rsp_uuid_low[63:62] == uuidg_pkg::VARIANT_BITS)
		else $error("UUID without valid version or variant");

	a_save_ts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_save_request |->
			rsp_save_timestamp == rsp_uuid_high[63:16]
			&& rsp_uuid_high[15:12] == uuidg_pkg::VER_NIB_TIME)
		else $error("save timestamp does not match the issued UUID");

endmodule

bind monotonic_uuid_v7_generator_core uuidg_checker u_uuidg_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_uuid_high      (rsp.uuid_high),
	.rsp_uuid_low       (rsp.uuid_low),
	.rsp_save_request   (rsp.save_request),
	.rsp_save_timestamp (rsp.save_timestamp)
);

// ===== tb/tb_top.sv =====
// Testbench for the UUID generator core: directed and random generate requests checked against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import uuidg_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic        steady     = 1'b0;
	int unsigned mismatches = 0;

	// predicted results, oldest first
	rsp_t   expected_uuids[$];
	cfg_t   gen_cfg;
	state_t gen_state;

	uuidg_req_if req_ch ();
	uuidg_rsp_if rsp_ch ();

	monotonic_uuid_v7_generator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [47:0] rand48();
		logic [31:0] upper;
		upper = $urandom;
		return {upper[15:0], $urandom};
	endfunction

	function automatic logic [63:0] byte_reverse(input logic [63:0] w);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = w[63-8*i -: 8];
		end
		return r;
	endfunction

	// Low word that lands k steps below the counter wrap once the mixer is applied.
	function automatic logic [63:0] wrap_seed_low(input int unsigned k);
		logic [63:0] lo;
		lo = rand64();
		lo[61:0] = 62'h3FFF_FFFF_FFFF_FFFF - 62'(k);
		return lo ^ byte_reverse(gen_cfg.entropy_mixer);
	endfunction

	task automatic predict_uuid(input logic [63:0] rh_in, input logic [63:0] rl_in,
			input logic [47:0] now_in, output rsp_t want);
		logic [63:0] rh;
		logic [63:0] rl;
		logic [63:0] now;
		logic [61:0] cnt_low;
		logic [11:0] cnt_high;
		logic        issued;
		want   = '0;
		rh     = rh_in;
		rl     = rl_in;
		now    = {16'd0, now_in};
		issued = 1'b0;
		if (gen_cfg.version_mode == MODE_RANDOM) begin
			if ((rh | rl) == '0) begin
				gen_state.store_high = '0;
				gen_state.store_low  = '0;
				want.status = ST_REJECTED;
			end else begin
				gen_state.store_high = {rh[63:16], VER_NIB_RANDOM, rh[11:0]};
				gen_state.store_low  = {VARIANT_BITS, rl[61:0]};
				want.uuid_high = gen_state.store_high;
				want.uuid_low  = gen_state.store_low;
			end
		end else if ((rh | rl) == '0 || now == '0) begin
			want.status = ST_REJECTED;
		end else begin
			rl ^= byte_reverse(gen_cfg.entropy_mixer);
			if (now < gen_state.last_timestamp &&
					now + gen_cfg.regression_threshold_ms < gen_state.last_timestamp) begin
				// big step back: random fallback, keep time and overflow state
				gen_state.store_high = {rh[63:16], VER_NIB_RANDOM, rh[11:0]};
				gen_state.store_low  = {VARIANT_BITS, rl[61:0]};
				want.uuid_high = gen_state.store_high;
				want.uuid_low  = gen_state.store_low;
			end else begin
				if (now > gen_state.last_timestamp) begin
					gen_state.last_timestamp = now[47:0];
					gen_state.store_high     = rh;
					gen_state.store_low      = rl;
					gen_state.overflow_flag  = 1'b0;
					issued = 1'b1;
				end else begin
					now = {16'd0, gen_state.last_timestamp};
					if (gen_state.overflow_flag) begin
						want.status = gen_cfg.overflow_wait ? ST_OVF_RETRY : ST_OVF_FAIL;
					end else if (gen_state.store_high[15:12] != VER_NIB_TIME) begin
						gen_state.store_high = rh;
						gen_state.store_low  = rl;
						issued = 1'b1;
					end else begin
						cnt_low = gen_state.store_low[61:0] + 62'd1;
						gen_state.store_low[61:0] = cnt_low;
						if (cnt_low != '0) begin
							issued = 1'b1;
						end else begin
							cnt_high = gen_state.store_high[11:0] + 12'd1;
							gen_state.store_high[11:0] = cnt_high;
							if (cnt_high != '0) begin
								issued = 1'b1;
							end else begin
								gen_state.overflow_flag = 1'b1;
								want.status = gen_cfg.overflow_wait ? ST_OVF_RETRY : ST_OVF_FAIL;
							end
						end
					end
				end
				if (issued) begin
					gen_state.store_high = {gen_state.last_timestamp, VER_NIB_TIME,
						gen_state.store_high[11:0]};
					gen_state.store_low[63:62] = VARIANT_BITS;
					want.uuid_high = gen_state.store_high;
					want.uuid_low  = gen_state.store_low;
					if (gen_cfg.save_enable &&
							now > {16'd0, gen_state.last_saved_time} + gen_cfg.save_interval_ms) begin
						gen_state.last_saved_time = now[47:0];
						want.save_request   = 1'b1;
						want.save_timestamp = now[47:0];
					end
				end
			end
		end
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_VERSION_MODE:  gen_cfg.version_mode            = val[2:0];
			REG_OVERFLOW_WAIT: gen_cfg.overflow_wait           = val[0];
			REG_ENTROPY_MIXER: gen_cfg.entropy_mixer           = val;
			REG_REGRESSION_MS: gen_cfg.regression_threshold_ms = val[31:0];
			REG_SAVE_ENABLE:   gen_cfg.save_enable             = val[0];
			REG_SAVE_INTERVAL: gen_cfg.save_interval_ms        = val[31:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(input logic [63:0] rh, input logic [63:0] rl,
			input logic [47:0] now);
		rsp_t want;
		while (!steady && $urandom_range(99) < 23) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.random_high <= rh;
		req_ch.random_low  <= rl;
		req_ch.now_ms      <= now;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_uuid(rh, rl, now, want);
		expected_uuids.push_back(want);
	endtask

	// Drop valid and wait until every outstanding transaction has returned.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (expected_uuids.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_rejects();
		send_request('0, '0, 48'd1000);
		send_request(rand64(), rand64(), '0);
	endtask

	task automatic test_time_ordering();
		send_request(rand64(), rand64(), 48'd1000);
		send_request(rand64(), rand64(), 48'd1000);
		send_request(rand64(), rand64(), 48'd1001);
		send_request(rand64(), rand64(), 48'd995);
		send_request(rand64(), rand64(), 48'd100000);
		send_request(rand64(), rand64(), 48'd50);
		// store now holds a random image, so the same millisecond takes fresh bits
		send_request(rand64(), rand64(), 48'd100000);
	endtask

	task automatic test_counter_overflow();
		logic [63:0] rh;
		drain();
		write_reg(REG_ENTROPY_MIXER, rand64());
		write_reg(REG_OVERFLOW_WAIT, 64'd0);
		rh = rand64();
		rh[11:0] = 12'h123;
		send_request(rh, wrap_seed_low(0), 48'd200000);
		send_request(rand64(), rand64(), 48'd200000);
		rh[11:0] = 12'hFFF;
		send_request(rh, wrap_seed_low(0), 48'd200001);
		send_request(rand64(), rand64(), 48'd200001);
		drain();
		write_reg(REG_OVERFLOW_WAIT, 64'd1);
		send_request(rand64(), rand64(), 48'd200001);
		send_request(rand64(), rand64(), 48'd200002);
	endtask

	task automatic test_save_requests();
		drain();
		write_reg(REG_SAVE_ENABLE, 64'd1);
		write_reg(REG_SAVE_INTERVAL, 64'd0);
		send_request(rand64(), rand64(), 48'd300000);
		send_request(rand64(), rand64(), 48'd300000);
		drain();
		write_reg(REG_SAVE_INTERVAL, 64'hFFFF_FFFF);
		send_request(rand64(), rand64(), 48'd300001);
		drain();
		write_reg(REG_REGRESSION_MS, 64'd0);
		send_request(rand64(), rand64(), 48'd299999);
		drain();
		write_reg(REG_REGRESSION_MS, 64'hFFFF_FFFF);
		send_request(rand64(), rand64(), 48'd1);
	endtask

	task automatic test_random_mode();
		drain();
		write_reg(REG_VERSION_MODE, 64'(MODE_RANDOM));
		send_request('0, '0, '0);
		send_request('1, '1, '1);
		send_request(rand64(), rand64(), rand48());
		drain();
		// codes other than the random one behave as time-ordered
		write_reg(REG_VERSION_MODE, 64'd5);
		send_request(rand64(), rand64(), 48'd300002);
		drain();
		write_reg(REG_VERSION_MODE, 64'd0);
		send_request(rand64(), rand64(), 48'd300002);
		drain();
		write_reg(REG_VERSION_MODE, 64'(MODE_RESET));
	endtask

	task automatic test_random_traffic();
		logic [63:0] rh;
		logic [63:0] rl;
		logic [47:0] base;
		logic [47:0] now;
		logic [2:0]  mode;
		int unsigned pick;
		for (int phase = 0; phase < 9; phase++) begin
			drain();
			mode = MODE_RESET;
			if (phase == 2 || phase == 7) begin
				mode = MODE_RANDOM;
			end else if (phase == 5) begin
				mode = 3'($urandom_range(0, 5));
				if (mode >= 3'd4) mode++;
			end
			write_reg(REG_VERSION_MODE, 64'(mode));
			write_reg(REG_OVERFLOW_WAIT, 64'(phase % 2));
			case (phase % 3)
				0: write_reg(REG_ENTROPY_MIXER, '0);
				1: write_reg(REG_ENTROPY_MIXER, '1);
				default: write_reg(REG_ENTROPY_MIXER, rand64());
			endcase
			case (phase % 4)
				0: write_reg(REG_REGRESSION_MS, 64'd0);
				1: write_reg(REG_REGRESSION_MS, 64'hFFFF_FFFF);
				2: write_reg(REG_REGRESSION_MS, 64'(REGRESSION_RESET));
				default: write_reg(REG_REGRESSION_MS, 64'($urandom_range(0, 200)));
			endcase
			write_reg(REG_SAVE_ENABLE, 64'($urandom_range(0, 1)));
			case (phase % 3)
				0: write_reg(REG_SAVE_INTERVAL, 64'd0);
				1: write_reg(REG_SAVE_INTERVAL, 64'hFFFF_FFFF);
				default: write_reg(REG_SAVE_INTERVAL, 64'($urandom_range(0, 20)));
			endcase
			steady = (phase == 3);
			for (int n = 0; n < 50; n++) begin
				base = (gen_state.last_timestamp == '0) ? 48'd1000 : gen_state.last_timestamp;
				rh   = rand64();
				rl   = rand64();
				now  = base;
				pick = $urandom_range(99);
				if (pick < 45) begin
					now = base;
				end else if (pick < 70) begin
					now = base + $urandom_range(1, 5);
				end else if (pick < 80) begin
					now = base - $urandom_range(1, 20);
				end else if (pick < 85) begin
					now = base - gen_cfg.regression_threshold_ms - 1 - $urandom_range(0, 1000);
				end else if (pick < 90) begin
					// seed a counter close to its wrap so that later requests can hit overflow
					if ($urandom_range(0, 1)) rh[11:0] = 12'hFFF;
					rl  = wrap_seed_low($urandom_range(0, 3));
					now = base + 1;
				end else if (pick < 93) begin
					now = '0;
				end else if (pick < 96) begin
					rh = '0;
					rl = '0;
				end else begin
					now = rand48();
				end
				send_request(rh, rl, now);
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_time_limits();
		drain();
		write_reg(REG_VERSION_MODE, 64'(MODE_RESET));
		write_reg(REG_REGRESSION_MS, 64'hFFFF_FFFF);
		send_request(rand64(), rand64(), '1);
		send_request(rand64(), rand64(), '1);
		send_request(rand64(), rand64(), 48'd1);
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_uuids.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: status=%0d hi=%h lo=%h save=%0b ts=%h",
						rsp_ch.status, rsp_ch.uuid_high, rsp_ch.uuid_low,
						rsp_ch.save_request, rsp_ch.save_timestamp);
				mismatches++;
			end else begin
				want = expected_uuids.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.uuid_high !== want.uuid_high ||
						rsp_ch.uuid_low !== want.uuid_low ||
						rsp_ch.save_request !== want.save_request ||
						rsp_ch.save_timestamp !== want.save_timestamp) begin
					if (mismatches < 10) begin
						$display("mismatch: expected status=%0d hi=%h lo=%h save=%0b ts=%h",
							want.status, want.uuid_high, want.uuid_low,
							want.save_request, want.save_timestamp);
						$display("          actual   status=%0d hi=%h lo=%h save=%0b ts=%h",
							rsp_ch.status, rsp_ch.uuid_high, rsp_ch.uuid_low,
							rsp_ch.save_request, rsp_ch.save_timestamp);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_VERSION_MODE;
		cfg_data           <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.random_high <= '0;
		req_ch.random_low  <= '0;
		req_ch.now_ms      <= '0;
		gen_cfg = '{version_mode: MODE_RESET, overflow_wait: 1'b0, entropy_mixer: '0,
			regression_threshold_ms: REGRESSION_RESET, save_enable: 1'b0,
			save_interval_ms: '0};
		gen_state = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejects();
		test_time_ordering();
		test_counter_overflow();
		test_save_requests();
		test_random_mode();
		test_random_traffic();
		test_time_limits();

		drain();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && expected_uuids.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/uuidg_pkg.sv
src/uuidg_if.sv
src/uuidg_cfg_regs.sv
src/uuidg_step.sv
src/monotonic_uuid_v7_generator_core.sv
src/uuidg_checker.sv
tb/tb_top.sv
